// ===== hw/rtl/msig_pkg.sv =====
package msig_pkg;

	localparam int MAX_PATTERN_BYTES_DEF = 32;
	localparam int PAT_BYTES = 32;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W = 3;
	localparam int LEN_W = 6;
	localparam int ADDR_W = 32;
	localparam int SEEN_W = 33;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PATTERN_0,
		REG_PATTERN_1,
		REG_PATTERN_2,
		REG_PATTERN_3,
		REG_CARE_MASK,
		REG_PATTERN_LENGTH,
		REG_BASE_ADDRESS,
		REG_SCAN_LENGTH
	} cfg_reg_e;

	typedef struct packed {
		logic [PAT_BYTES-1:0][7:0] pattern;
		logic [PAT_BYTES-1:0]      care_mask;
		logic [LEN_W-1:0]          pattern_length;
		logic [ADDR_W-1:0]         base_address;
		logic [31:0]               scan_length;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first_of_scan;
	} in_item_t;

	typedef struct packed {
		logic              hit;
		logic [ADDR_W-1:0] hit_address;
		logic              found_so_far;
	} out_item_t;

	typedef struct packed {
		logic valid;
		logic restart;
	} s1_ctl_t;

endpackage

// ===== hw/rtl/msig_if.sv =====
interface msig_in_if;
	logic               valid;
	logic               ready;
	msig_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface msig_out_if;
	logic                valid;
	logic                ready;
	msig_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/masked_byte_signature_scan.sv =====
// channel   dir  handshake          payload
// in_ch     in   valid/ready        data_byte[7:0], first_of_scan
// out_ch    out  valid/ready        hit, hit_address[31:0], found_so_far
// cfg       in   cfg_we (no ready)  cfg_index[2:0], cfg_data[63:0]
//
// one byte per cycle sustained unless the output stalls
// stage one holds the byte window and count, stage two the match and result
// window compare is a parallel masked compare over the used pattern bytes
// arst_n clears config (len to one), byte count, found mark, valid flags
// a stalled output holds stage two, then stage one, then input ready drops
module masked_byte_signature_scan #(
	parameter int MAX_PATTERN_BYTES = msig_pkg::MAX_PATTERN_BYTES_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [msig_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [msig_pkg::CFG_DATA_W-1:0]      cfg_data,
	msig_in_if.sink                              in_ch,
	msig_out_if.source                           out_ch
);
	import msig_pkg::*;

	cfg_t                                 cfg;
	logic [MAX_PATTERN_BYTES-1:0][7:0]    window_s1;
	logic [SEEN_W-1:0]                    seen_s1;
	s1_ctl_t                              ctl_s1;
	logic                                 adv;

	msig_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	msig_win #(
		.MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
	) u_win (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.adv       (adv),
		.window_s1 (window_s1),
		.seen_s1   (seen_s1),
		.ctl_s1    (ctl_s1)
	);

	msig_match #(
		.MAX_PATTERN_BYTES (MAX_PATTERN_BYTES)
	) u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.window_s1 (window_s1),
		.seen_s1   (seen_s1),
		.ctl_s1    (ctl_s1),
		.adv       (adv),
		.out_ch    (out_ch)
	);

endmodule

// ===== hw/rtl/msig_cfg.sv =====
module msig_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [msig_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [msig_pkg::CFG_DATA_W-1:0]      cfg_data,
	output msig_pkg::cfg_t                       cfg
);
	import msig_pkg::*;

	logic [CFG_DATA_W-1:0] pat0_q, pat1_q, pat2_q, pat3_q;
	logic [PAT_BYTES-1:0]  care_q;
	logic [LEN_W-1:0]      len_q;
	logic [ADDR_W-1:0]     base_q;
	logic [31:0]           scan_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat0_q <= '0;
			pat1_q <= '0;
			pat2_q <= '0;
			pat3_q <= '0;
			care_q <= '0;
			len_q  <= LEN_W'(1);
			base_q <= '0;
			scan_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_e'(cfg_index))
				REG_PATTERN_0:      pat0_q <= cfg_data;
				REG_PATTERN_1:      pat1_q <= cfg_data;
				REG_PATTERN_2:      pat2_q <= cfg_data;
				REG_PATTERN_3:      pat3_q <= cfg_data;
				REG_CARE_MASK:      care_q <= cfg_data[PAT_BYTES-1:0];
				REG_PATTERN_LENGTH: len_q  <= cfg_data[LEN_W-1:0];
				REG_BASE_ADDRESS:   base_q <= cfg_data[ADDR_W-1:0];
				REG_SCAN_LENGTH:    scan_q <= cfg_data[31:0];
				default:            ;
			endcase
		end
	end

	assign cfg.pattern        = {pat3_q, pat2_q, pat1_q, pat0_q};
	assign cfg.care_mask      = care_q;
	assign cfg.pattern_length = len_q;
	assign cfg.base_address   = base_q;
	assign cfg.scan_length    = scan_q;

endmodule

// ===== hw/rtl/msig_win.sv =====
module msig_win #(
	parameter int MAX_PATTERN_BYTES = msig_pkg::MAX_PATTERN_BYTES_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	msig_in_if.sink                                 in_ch,
	input  logic                                    adv,
	output logic [MAX_PATTERN_BYTES-1:0][7:0]       window_s1,
	output logic [msig_pkg::SEEN_W-1:0]             seen_s1,
	output msig_pkg::s1_ctl_t                       ctl_s1
);
	import msig_pkg::*;

	logic                  accept;
	logic [SEEN_W-1:0]     seen_base;
	logic                  valid_s1;
	logic                  restart_s1;

	assign in_ch.ready = !valid_s1 || adv;
	assign accept      = in_ch.valid && in_ch.ready;
	assign seen_base   = in_ch.data.first_of_scan ? '0 : seen_s1;

	// newest byte at index 0
	always_ff @(posedge clk) begin
		if (accept) begin
			window_s1[0] <= in_ch.data.data_byte;
			for (int i = 1; i < MAX_PATTERN_BYTES; i++) begin
				window_s1[i] <= window_s1[i-1];
			end
			restart_s1 <= in_ch.data.first_of_scan;
		end
	end

	// saturating byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_s1  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				seen_s1  <= (&seen_base) ? seen_base : seen_base + SEEN_W'(1);
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	assign ctl_s1.valid   = valid_s1;
	assign ctl_s1.restart = restart_s1;

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ch.ready)
		else $error("input not ready while stage one empty");

	a_seen_restart: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_ch.data.first_of_scan |=> seen_s1 == SEEN_W'(1))
		else $error("byte count not restarted");

	a_hold_when_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(seen_s1))
		else $error("stage one lost while stalled");

endmodule

// ===== hw/rtl/msig_match.sv =====
module msig_match #(
	parameter int MAX_PATTERN_BYTES = msig_pkg::MAX_PATTERN_BYTES_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  msig_pkg::cfg_t                          cfg,
	input  logic [MAX_PATTERN_BYTES-1:0][7:0]       window_s1,
	input  logic [msig_pkg::SEEN_W-1:0]             seen_s1,
	input  msig_pkg::s1_ctl_t                       ctl_s1,
	output logic                                    adv,
	msig_out_if.source                              out_ch
);
	import msig_pkg::*;

	localparam int IW = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

	logic [LEN_W-1:0]  len_use;
	logic [SEEN_W-1:0] start;
	logic              in_range;
	logic              mismatch;
	logic              found_eff;
	logic              hit;
	logic              found_q;
	logic              valid_s2;
	out_item_t         res_s2;

	always_comb begin
		if (cfg.pattern_length == '0) begin
			len_use = LEN_W'(1);
		end else if (cfg.pattern_length > LEN_W'(MAX_PATTERN_BYTES)) begin
			len_use = LEN_W'(MAX_PATTERN_BYTES);
		end else begin
			len_use = cfg.pattern_length;
		end
	end

	assign start    = seen_s1 - SEEN_W'(len_use);
	assign in_range = (seen_s1 >= SEEN_W'(len_use)) && (start < SEEN_W'(cfg.scan_length));

	// pattern byte i lines up with window slot len-1-i
	always_comb begin
		logic [LEN_W-1:0] idx;
		mismatch = 1'b0;
		idx      = '0;
		for (int i = 0; i < MAX_PATTERN_BYTES; i++) begin
			idx = len_use - LEN_W'(1) - LEN_W'(i);
			if ((LEN_W'(i) < len_use) && cfg.care_mask[i]
				&& (window_s1[idx[IW-1:0]] != cfg.pattern[i])) begin
				mismatch = 1'b1;
			end
		end
	end

	assign found_eff = ctl_s1.restart ? 1'b0 : found_q;
	assign hit       = !found_eff && in_range && !mismatch;
	assign adv       = ctl_s1.valid && (!valid_s2 || out_ch.ready);

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2.hit          <= hit;
			res_s2.hit_address  <= hit ? cfg.base_address + start[ADDR_W-1:0] : '0;
			res_s2.found_so_far <= found_eff || hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q  <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv) begin
				found_q  <= found_eff || hit;
				valid_s2 <= 1'b1;
			end else if (out_ch.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	assign out_ch.valid = valid_s2;
	assign out_ch.data  = res_s2;

	a_hit_sets_found: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.hit |-> res_s2.found_so_far && found_q)
		else $error("hit without found mark");

	a_no_addr_without_hit: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !res_s2.hit |-> res_s2.hit_address == '0)
		else $error("address without hit");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !ctl_s1.restart && found_q |=> !res_s2.hit)
		else $error("second hit in one scan");

endmodule

// ===== verif/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import msig_pkg::*;

	localparam int RANDOM_ITEMS = 1600;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS = 10;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [7:0] CHAR_X = "x";

	typedef enum logic [1:0] {
		SETUP_KEEP,
		SETUP_SINGLE_X,
		SETUP_SHORT_SCAN,
		SETUP_GAPPED
	} setup_e;

	typedef struct packed {
		setup_e     setup;
		logic [7:0] data_byte;
		logic       first;
		logic       typed;
		out_item_t  want;
	} stim_row_t;

	localparam int NUM_ROWS = 17;
	localparam stim_row_t ROWS [NUM_ROWS] = '{
		'{SETUP_KEEP,       8'h00,  1'b0, 1'b1, '{1'b0, 32'h0000_0000, 1'b0}},
		'{SETUP_KEEP,       8'hFF,  1'b1, 1'b1, '{1'b0, 32'h0000_0000, 1'b0}},
		'{SETUP_SINGLE_X,   8'h41,  1'b1, 1'b1, '{1'b0, 32'h0000_0000, 1'b0}},
		'{SETUP_KEEP,       CHAR_X, 1'b0, 1'b1, '{1'b1, 32'hFFFF_FFFF, 1'b1}},
		'{SETUP_KEEP,       CHAR_X, 1'b0, 1'b1, '{1'b0, 32'h0000_0000, 1'b1}},
		'{SETUP_KEEP,       CHAR_X, 1'b1, 1'b1, '{1'b1, 32'hFFFF_FFFE, 1'b1}},
		'{SETUP_KEEP,       8'h41,  1'b1, 1'b1, '{1'b0, 32'h0000_0000, 1'b0}},
		'{SETUP_KEEP,       8'h41,  1'b0, 1'b1, '{1'b0, 32'h0000_0000, 1'b0}},
		'{SETUP_KEEP,       CHAR_X, 1'b0, 1'b1, '{1'b1, 32'h0000_0000, 1'b1}},
		'{SETUP_SHORT_SCAN, 8'hFF,  1'b1, 1'b1, '{1'b1, 32'h0000_1000, 1'b1}},
		'{SETUP_KEEP,       8'hFF,  1'b1, 1'b1, '{1'b1, 32'h0000_1000, 1'b1}},
		'{SETUP_KEEP,       8'hFE,  1'b1, 1'b1, '{1'b0, 32'h0000_0000, 1'b0}},
		'{SETUP_KEEP,       8'hFF,  1'b0, 1'b1, '{1'b0, 32'h0000_0000, 1'b0}},
		'{SETUP_GAPPED,     8'h12,  1'b1, 1'b0, '{1'b0, 32'h0000_0000, 1'b0}},
		'{SETUP_KEEP,       8'h99,  1'b0, 1'b0, '{1'b0, 32'h0000_0000, 1'b0}},
		'{SETUP_KEEP,       8'h34,  1'b0, 1'b1, '{1'b1, 32'h0000_0000, 1'b1}},
		'{SETUP_KEEP,       8'h34,  1'b1, 1'b0, '{1'b0, 32'h0000_0000, 1'b0}}
	};

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	msig_in_if  in_ch ();
	msig_out_if out_ch ();

	masked_byte_signature_scan uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow of the scanner: configuration and state
	logic [PAT_BYTES-1:0][7:0] pat_bytes;
	logic [31:0]               care;
	logic [LEN_W-1:0]          plen;
	logic [31:0]               base;
	logic [31:0]               scan_len;
	logic [PAT_BYTES-1:0][7:0] window;
	logic [SEEN_W-1:0]         seen;
	logic                      found;

	out_item_t scan_results [$];
	int        mismatches = 0;
	int        bytes_sent = 0;
	int        idle_cycles = 0;
	int        stall_left = 0;
	bit        no_idle = 1'b0;
	logic      row_typed = 1'b0;
	out_item_t row_want = '0;

	function automatic int used_len();
		if (plen == 0)
			return 1;
		if (plen > PAT_BYTES)
			return PAT_BYTES;
		return int'(plen);
	endfunction

	function automatic void shadow_reset();
		pat_bytes = '0;
		care = '0;
		plen = LEN_W'(1);
		base = '0;
		scan_len = '0;
		window = '0;
		seen = '0;
		found = 1'b0;
	endfunction

	function automatic void shadow_write(cfg_reg_e idx, logic [63:0] v);
		case (idx)
			REG_PATTERN_0, REG_PATTERN_1, REG_PATTERN_2, REG_PATTERN_3: begin
				for (int j = 0; j < 8; j++)
					pat_bytes[int'(idx) * 8 + j] = v[j*8 +: 8];
			end
			REG_CARE_MASK: care = v[31:0];
			REG_PATTERN_LENGTH: plen = v[LEN_W-1:0];
			REG_BASE_ADDRESS: base = v[31:0];
			REG_SCAN_LENGTH: scan_len = v[31:0];
			default: ;
		endcase
	endfunction

	// shift one byte in and look for the first masked match of this scan
	function automatic out_item_t shift_and_match(logic [7:0] b, logic restart);
		out_item_t         r;
		int                len;
		logic [SEEN_W-1:0] start;
		bit                ok;
		r = '0;
		len = used_len();
		if (restart) begin
			seen = '0;
			found = 1'b0;
		end
		window = {window[PAT_BYTES-2:0], b};
		if (seen != {SEEN_W{1'b1}})
			seen = seen + SEEN_W'(1);
		if (!found && seen >= SEEN_W'(len)) begin
			start = seen - SEEN_W'(len);
			if (start < {1'b0, scan_len}) begin
				ok = 1'b1;
				for (int i = 0; i < len; i++)
					if (care[i] && window[len - 1 - i] != pat_bytes[i])
						ok = 1'b0;
				if (ok) begin
					found = 1'b1;
					r.hit = 1'b1;
					r.hit_address = base + start[31:0];
				end
			end
		end
		r.found_so_far = found;
		return r;
	endfunction

	// transfers on both channels, result check and watchdog
	always @(posedge clk) begin
		out_item_t got;
		out_item_t want;
		bit        moved;
		moved = 1'b0;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				moved = 1'b1;
				want = shift_and_match(in_ch.data.data_byte, in_ch.data.first_of_scan);
				scan_results.push_back(row_typed ? row_want : want);
			end
			if (out_ch.valid && out_ch.ready) begin
				moved = 1'b1;
				got = out_ch.data;
				stall_left = no_idle ? 0 : $urandom_range(0, 7);
				if (scan_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("unexpected result: hit=%0b addr=%h found=%0b",
							got.hit, got.hit_address, got.found_so_far);
				end else begin
					want = scan_results.pop_front();
					if (got.hit !== want.hit || got.hit_address !== want.hit_address ||
							got.found_so_far !== want.found_so_far) begin
						mismatches++;
						if (mismatches <= MAX_REPORTS)
							$display("mismatch: exp %0b %h %0b, got %0b %h %0b",
								want.hit, want.hit_address, want.found_so_far,
								got.hit, got.hit_address, got.found_so_far);
					end
				end
			end
		end
		if (moved)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (stall_left > 0) begin
			out_ch.ready <= 1'b0;
			stall_left--;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	task automatic send_byte(logic [7:0] b, logic first, logic typed, out_item_t want);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= '{data_byte: b, first_of_scan: first};
		row_typed = typed;
		row_want = want;
		do
			@(posedge clk);
		while (!in_ch.ready);
		bytes_sent++;
		@(negedge clk);
	endtask

	// stop sending and let every outstanding result come back
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (scan_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_e idx, logic [63:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		shadow_write(idx, v);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_setup(setup_e s);
		drain();
		case (s)
			SETUP_SINGLE_X: begin
				write_reg(REG_PATTERN_0, {{56{1'b1}}, CHAR_X});
				write_reg(REG_CARE_MASK, 64'h1);
				write_reg(REG_PATTERN_LENGTH, 64'd1);
				write_reg(REG_BASE_ADDRESS, 64'hFFFF_FFFE);
				write_reg(REG_SCAN_LENGTH, 64'hFFFF_FFFF);
			end
			SETUP_SHORT_SCAN: begin
				// length field reads zero, upper data bits dropped
				write_reg(REG_PATTERN_0, 64'hFF);
				write_reg(REG_CARE_MASK, 64'hFFFF_FFFF_FFFF_FFFF);
				write_reg(REG_PATTERN_LENGTH, 64'h40);
				write_reg(REG_BASE_ADDRESS, 64'h1000);
				write_reg(REG_SCAN_LENGTH, 64'hFFFF_FFFF_0000_0001);
			end
			SETUP_GAPPED: begin
				// middle byte is a wildcard, most care bits past the length set
				write_reg(REG_PATTERN_0, 64'h0000_0000_0034_5612);
				write_reg(REG_CARE_MASK, 64'hFFFF_FFF5);
				write_reg(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFC3);
				write_reg(REG_BASE_ADDRESS, 64'h0);
				write_reg(REG_SCAN_LENGTH, 64'hFFFF_FFFF);
			end
			default: ;
		endcase
	endtask

	task automatic random_setup();
		logic [63:0] v;
		drain();
		for (int n = 0; n < 4; n++) begin
			case ($urandom_range(0, 7))
				0: v = '1;
				1: v = '0;
				default: v = {$urandom(), $urandom()};
			endcase
			write_reg(cfg_reg_e'(n), v);
		end
		case ($urandom_range(0, 4))
			0: v = {$urandom(), 32'hFFFF_FFFF};
			1: v = {$urandom(), 32'h0};
			2: v = {$urandom(), $urandom() & $urandom()};
			default: v = {$urandom(), $urandom()};
		endcase
		write_reg(REG_CARE_MASK, v);
		case ($urandom_range(0, 9))
			6, 7: v = 64'($urandom_range(9, 32));
			8: v = ($urandom_range(0, 1) != 0) ? 64'd0 : 64'd32;
			9: v = 64'($urandom_range(33, 63));
			default: v = 64'($urandom_range(1, 8));
		endcase
		v[63:LEN_W] = (64-LEN_W)'({$urandom(), $urandom()});
		write_reg(REG_PATTERN_LENGTH, v);
		case ($urandom_range(0, 3))
			0: v = {$urandom(), 32'hFFFF_FFFF - 32'($urandom_range(0, 40))};
			1: v = {$urandom(), 32'h0};
			default: v = {$urandom(), $urandom()};
		endcase
		write_reg(REG_BASE_ADDRESS, v);
		case ($urandom_range(0, 7))
			0: v = {$urandom(), 32'h0};
			1: v = {$urandom(), 32'hFFFF_FFFF};
			2: v = {$urandom(), $urandom()};
			default: v = {$urandom(), 32'($urandom_range(1, 40))};
		endcase
		write_reg(REG_SCAN_LENGTH, v);
	endtask

	function automatic logic [7:0] noise_byte();
		if ($urandom_range(0, 3) == 0)
			return pat_bytes[5'($urandom_range(0, PAT_BYTES - 1))];
		return 8'($urandom_range(0, 255));
	endfunction

	// one scan: noise, the pattern with random wildcard bytes, maybe absent, broken or repeated
	task automatic send_scan();
		int         elen;
		int         pre;
		int         post;
		int         copies;
		int         bad;
		int         n;
		bit         restart;
		bit         corrupt;
		logic [7:0] b;
		elen = used_len();
		restart = ($urandom_range(0, 7) != 0);
		pre = $urandom_range(0, 10);
		post = $urandom_range(0, 6);
		case ($urandom_range(0, 7))
			0: copies = 0;
			1, 2: copies = 2;
			default: copies = 1;
		endcase
		n = 0;
		for (int k = 0; k < pre; k++) begin
			send_byte(noise_byte(), restart && n == 0, 1'b0, '0);
			n++;
		end
		for (int c = 0; c < copies; c++) begin
			corrupt = ($urandom_range(0, 3) == 0);
			bad = $urandom_range(0, elen - 1);
			for (int i = 0; i < elen; i++) begin
				b = care[i] ? pat_bytes[i] : 8'($urandom_range(0, 255));
				if (corrupt && i == bad)
					b = b ^ 8'($urandom_range(1, 255));
				send_byte(b, restart && n == 0, 1'b0, '0);
				n++;
			end
		end
		for (int k = 0; k < post; k++) begin
			send_byte(noise_byte(), restart && n == 0, 1'b0, '0);
			n++;
		end
	endtask

	initial begin
		int phase_end;
		int random_end;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_PATTERN_0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		shadow_reset();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < NUM_ROWS; r++) begin
			if (ROWS[r].setup != SETUP_KEEP)
				apply_setup(ROWS[r].setup);
			send_byte(ROWS[r].data_byte, ROWS[r].first, ROWS[r].typed, ROWS[r].want);
		end

		random_end = bytes_sent + RANDOM_ITEMS;
		while (bytes_sent < random_end) begin
			no_idle = 1'b0;
			random_setup();
			no_idle = ($urandom_range(0, 4) == 0);
			phase_end = bytes_sent + $urandom_range(60, 200);
			while (bytes_sent < phase_end)
				send_scan();
		end

		no_idle = 1'b0;
		drain();
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && scan_results.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
